/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies the consequent later, checked with |=> ##1
`define ASSERT_IMPL2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

/* rtl/sot_pkg.sv */
// ----------------------------------------------------------------------------
// sot_pkg
// Types and codes shared by the stream ownership table modules.
// ----------------------------------------------------------------------------
package sot_pkg;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int SID_W    = 16;
    localparam int CLIENT_W = 16;
    localparam int DOMAIN_W = 16;
    localparam int INST_W   = 4;
    localparam int STATUS_W = 2;

    // Default table depth
    localparam int DEF_TABLE_ENTRIES = 256;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_ASSIGN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Request beat
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SID_W-1:0]    stream_id;
        logic [CLIENT_W-1:0] client;
        logic [DOMAIN_W-1:0] domain;
        logic [INST_W-1:0]   instance_id;
    } t_req;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLIENT_W-1:0] found_client;
        logic [DOMAIN_W-1:0] found_domain;
        logic [INST_W-1:0]   found_instance;
    } t_rsp;

    // One table entry
    typedef struct packed {
        logic                active;
        logic [DOMAIN_W-1:0] domain;
        logic [CLIENT_W-1:0] client;
        logic [INST_W-1:0]   inst;
    } t_entry;

endpackage

/* rtl/sot_mem.sv */
// ----------------------------------------------------------------------------
// sot_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sot_mem #(
    parameter int DEPTH = sot_pkg::DEF_TABLE_ENTRIES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  sot_pkg::t_entry   i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output sot_pkg::t_entry   o_rdata
);

    sot_pkg::t_entry r_mem [DEPTH];
    sot_pkg::t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data, enabled by i_re
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sot_ctrl.sv */
// ----------------------------------------------------------------------------
// sot_ctrl
// Request sequencer: clearing pass, table read, check and write back.
// ----------------------------------------------------------------------------
module sot_ctrl #(
    parameter int TABLE_ENTRIES = sot_pkg::DEF_TABLE_ENTRIES,
    parameter int AW            = $clog2(TABLE_ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  sot_pkg::t_req     i_req,
    output logic              o_done,
    output sot_pkg::t_rsp     o_rsp,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_raddr,
    input  sot_pkg::t_entry   i_mem_rdata,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output sot_pkg::t_entry   o_mem_wdata
);

    localparam logic [sot_pkg::SID_W:0] N_ENTRIES = (sot_pkg::SID_W + 1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0]           LAST_IDX  = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_idx;
    sot_pkg::t_req   r_req;
    logic            r_done;
    sot_pkg::t_rsp   r_rsp;
    sot_pkg::t_rsp   n_rsp;

    logic            accept;
    logic            req_in_range;
    logic            cur_in_range;
    sot_pkg::t_entry rd;

    assign accept       = i_start && (r_state == S_IDLE);
    assign req_in_range = {1'b0, i_req.stream_id} < N_ENTRIES;
    assign cur_in_range = {1'b0, r_req.stream_id} < N_ENTRIES;
    assign rd           = i_mem_rdata;

    // Table read is issued on the accepting edge, for in-range stream IDs only
    assign o_mem_re    = accept && req_in_range;
    assign o_mem_raddr = i_req.stream_id[AW-1:0];

    // Decide result and write back
    always_comb begin
        n_rsp        = '0;
        n_rsp.status = sot_pkg::ST_INVALID;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_req.stream_id[AW-1:0];
        o_mem_wdata  = rd;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_idx;
                o_mem_wdata = '0;
            end
            S_EXEC: begin
                if (cur_in_range) begin
                    unique case (r_req.mode)
                        sot_pkg::MODE_ASSIGN: begin
                            if (rd.active && (rd.domain != r_req.domain)) begin
                                n_rsp.status = sot_pkg::ST_BUSY;
                            end else begin
                                n_rsp.status       = sot_pkg::ST_OK;
                                o_mem_we           = 1'b1;
                                o_mem_wdata.active = 1'b1;
                                o_mem_wdata.domain = r_req.domain;
                                o_mem_wdata.client = r_req.client;
                                o_mem_wdata.inst   = r_req.instance_id;
                            end
                        end
                        sot_pkg::MODE_RELEASE: begin
                            if (rd.active && (rd.inst == r_req.instance_id)) begin
                                n_rsp.status       = sot_pkg::ST_OK;
                                o_mem_we           = 1'b1;
                                o_mem_wdata.active = 1'b0;
                                o_mem_wdata.domain = '0;
                            end
                        end
                        sot_pkg::MODE_LOOKUP: begin
                            if (rd.active) begin
                                n_rsp.status         = sot_pkg::ST_OK;
                                n_rsp.found_client   = rd.client;
                                n_rsp.found_domain   = rd.domain;
                                n_rsp.found_instance = rd.inst;
                            end else begin
                                n_rsp.status = sot_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_rsp.status = sot_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
            r_rsp     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_done  <= 1'b1;
                    r_rsp   <= n_rsp;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* rtl/stream_ownership_table.sv */
// ----------------------------------------------------------------------------
// stream_ownership_table
// Directly indexed ownership table of DMA stream IDs: assign, release, lookup.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result is shown
// on o_rsp with o_done high for one cycle, after passing the table read
// register and the result register; there is no way to hold a result back,
// so capture it on o_done. A new request may be accepted while o_done is
// high; busy stays high while a request is in flight, through the table
// read and then the check and write back. After reset the table is swept
// clear, one entry a cycle, so busy stays high until every entry is cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stream_ownership_table #(
    parameter int TABLE_ENTRIES = sot_pkg::DEF_TABLE_ENTRIES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  sot_pkg::t_req   i_req,
    output logic            o_done,
    output sot_pkg::t_rsp   o_rsp
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    sot_pkg::t_entry mem_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    sot_pkg::t_entry mem_wdata;

    logic            req_accept;
    logic            rsp_fields_zero;

    // Sequencer
    sot_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata)
    );

    // Entry store
    sot_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Terms for the checks below
    assign req_accept      = start && !busy;
    assign rsp_fields_zero = (o_rsp.found_client == '0) && (o_rsp.found_domain == '0)
                             && (o_rsp.found_instance == '0);

    // Every accepted beat yields its result, after the table read and result registers
    `ASSERT_IMPL2(a_result_follows, i_clk, i_rst_n, req_accept, o_done, "missing result")

    // A result only follows an accepted beat
    `ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_done, $past(req_accept, 2), "spurious result")

    // Found fields are zero unless the result is a successful lookup
    `ASSERT_IMPL(a_zero_fields, i_clk, i_rst_n, o_done && (o_rsp.status != sot_pkg::ST_OK), rsp_fields_zero, "nonzero found fields")

endmodule
